// ===== src/osb_pkg.sv =====
// ----------------------------------------------------------------------------
// osb_pkg
// Shared types and constants of the oscillator bank noise source.
// ----------------------------------------------------------------------------
package osb_pkg;

  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned COS_W    = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // rounding of the Q31 product down to Q3.20
  localparam int unsigned ROUND_SHIFT = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_INC   = 2'd0,
    CFG_STEP_INC   = 2'd1,
    CFG_ACTIVE_CNT = 2'd2,
    CFG_OUT_GAIN   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_SCALE,
    ST_OUT
  } state_e;

  localparam logic [PHASE_W-1:0] BASE_INC_RST   = '0;
  localparam logic [PHASE_W-1:0] STEP_INC_RST   = '0;
  localparam logic [COUNT_W-1:0] ACTIVE_CNT_RST = 9'd256;
  localparam logic [GAIN_W-1:0]  OUT_GAIN_RST   = 16'd512;

endpackage

// ===== src/osb_phase_ram.sv =====
// ----------------------------------------------------------------------------
// osb_phase_ram
// Phase store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module osb_phase_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/osb_cos_rom.sv =====
// ----------------------------------------------------------------------------
// osb_cos_rom
// Q1.15 cosine table, built at elaboration, with registered read data.
// ----------------------------------------------------------------------------
module osb_cos_rom #(
  parameter int unsigned TABLE_BITS = 10
) (
  input  logic                         clk_i,
  input  logic [TABLE_BITS-1:0]        addr_i,
  output logic signed [osb_pkg::COS_W-1:0] data_o
);
  import osb_pkg::*;

  localparam int unsigned ROM_SIZE     = 1 << TABLE_BITS;
  localparam int unsigned QUARTER_BITS = TABLE_BITS - 2;
  localparam int unsigned QSIZE        = 1 << QUARTER_BITS;
  localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;

  typedef logic signed [COS_W-1:0] rom_t [ROM_SIZE];

  // cos over a quarter turn, Horner series to x^10, each stage held at zero
  function automatic logic [COS_W-1:0] quarter_cos(input int unsigned m);
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] d;
    logic [63:0] v;
    t  = 64'(m) << (30 - QUARTER_BITS);
    x  = (t * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    h  = Q30_ONE;
    d  = (x2 * h) / 64'd90;
    h  = (d > Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = (x2 * h) / 64'd56;
    h  = (d > Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = (x2 * h) / 64'd30;
    h  = (d > Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = (x2 * h) / 64'd12;
    h  = (d > Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = (x2 * h) / 64'd2;
    h  = (d > Q30_ONE) ? 64'd0 : Q30_ONE - d;
    v  = (h * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[COS_W-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    int unsigned quad;
    int unsigned r;
    logic signed [COS_W-1:0] q;
    for (int unsigned k = 0; k < ROM_SIZE; k++) begin
      quad = (k >> QUARTER_BITS) & 3;
      r    = k & (QSIZE - 1);
      unique case (quad)
        0: begin
          q = $signed(quarter_cos(r));
          rom[k] = q;
        end
        1: begin
          q = $signed(quarter_cos(QSIZE - r));
          rom[k] = -q;
        end
        2: begin
          q = $signed(quarter_cos(r));
          rom[k] = -q;
        end
        default: begin
          q = $signed(quarter_cos(QSIZE - r));
          rom[k] = q;
        end
      endcase
    end
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

  logic signed [COS_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= ROM[addr_i];
  end

  assign data_o = data_q;

endmodule

// ===== src/osb_scaler.sv =====
// ----------------------------------------------------------------------------
// osb_scaler
// Gain multiply, round half up to Q3.20 and saturate; two register stages.
// ----------------------------------------------------------------------------
module osb_scaler #(
  parameter int unsigned ACC_W = 25
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [ACC_W-1:0]            acc_i,
  input  logic [osb_pkg::GAIN_W-1:0]         gain_i,
  output logic                               done_o,
  output logic signed [osb_pkg::SAMPLE_W-1:0] sample_o
);
  import osb_pkg::*;

  localparam int unsigned PROD_W = ACC_W + GAIN_W + 1;
  localparam int unsigned EXT_W  = (PROD_W + 1 > SAMPLE_W + ROUND_SHIFT + 1) ?
                                   PROD_W + 1 : SAMPLE_W + ROUND_SHIFT + 1;
  localparam logic signed [EXT_W-1:0] SAT_HI   = EXT_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] SAT_LO   = -SAT_HI - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] HALF_LSB = EXT_W'(1 << (ROUND_SHIFT - 1));

  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic                       mul_vld_q;
  logic signed [EXT_W-1:0]    biased;
  logic signed [EXT_W-1:0]    shifted;
  logic signed [SAMPLE_W-1:0] sample_d, sample_q;
  logic                       done_q;

  assign prod_d = acc_i * $signed({1'b0, gain_i});

  always_comb begin
    biased  = EXT_W'(prod_q) + HALF_LSB;
    shifted = biased >>> ROUND_SHIFT;
    priority if (shifted > SAT_HI) begin
      sample_d = SAT_HI[SAMPLE_W-1:0];
    end else if (shifted < SAT_LO) begin
      sample_d = SAT_LO[SAMPLE_W-1:0];
    end else begin
      sample_d = shifted[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod_d;
    end
    if (mul_vld_q) begin
      sample_q <= sample_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      mul_vld_q <= start_i;
      done_q    <= mul_vld_q;
    end
  end

  assign done_o   = done_q;
  assign sample_o = sample_q;

endmodule

// ===== src/oscillator_bank_noise_source.sv =====
// ----------------------------------------------------------------------------
// oscillator_bank_noise_source
// Bank of phase accumulators whose summed cosines form a noise sample.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): req_type_i = 1 loads phase_value_i
// into oscillator osc_index_i (indexes past the bank are dropped);
// req_type_i = 0 is a tick that advances and sums the active oscillators
// and returns one sample_o on the output channel.
// A tick walks the phase store one oscillator per cycle through a
// read-add-write pipeline (phase RAM read, add and write back, cosine ROM
// read, accumulate), then multiplies and saturates in two stages.
// One item is in work at a time.
// Configuration (cfg_valid_i/cfg_index_i/cfg_data_i) is always ready; users
// must write it while no tick is in flight, which the block does not enforce.
// After reset the phase store is cleared one entry per cycle, all
// MAX_OSCILLATORS entries of it; in_ready_o stays low meanwhile.
// The finished sample sits in an output register; a new item is taken while
// it waits, but the next tick holds at its end until that transfer is done.
// ----------------------------------------------------------------------------
module oscillator_bank_noise_source #(
  parameter int unsigned MAX_OSCILLATORS = 256,
  parameter int unsigned COS_TABLE_BITS  = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [osb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [osb_pkg::INDEX_W-1:0]         osc_index_i,
  input  logic [osb_pkg::PHASE_W-1:0]         phase_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [osb_pkg::SAMPLE_W-1:0] sample_o
);
  import osb_pkg::*;

  localparam int unsigned IDX_W  = (MAX_OSCILLATORS > 1) ? $clog2(MAX_OSCILLATORS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_OSCILLATORS + 1);
  localparam int unsigned ACC_W  = COS_W + CNT_W;
  localparam int unsigned CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned LDC_W  = (IDX_W + 1 > INDEX_W) ? IDX_W + 1 : INDEX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_OSCILLATORS - 1);

  // configuration
  logic [PHASE_W-1:0] base_inc_q, step_inc_q;
  logic [COUNT_W-1:0] active_cnt_q;
  logic [GAIN_W-1:0]  out_gain_q;

  state_e state_q, state_d;

  logic [CNT_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [PHASE_W-1:0] inc_q, inc_d;
  logic [PHASE_W-1:0] s1_inc_q;
  logic [IDX_W-1:0]   s1_addr_q;
  logic               s1_vld_q, s2_vld_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic               out_load;

  logic               in_xfer, issue, scale_start, scale_done;
  logic [CMP_W-1:0]   cnt_cmp;
  logic [LDC_W-1:0]   ld_idx;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr;
  logic [PHASE_W-1:0] ram_wdata, ram_rdata, new_phase;
  logic signed [COS_W-1:0]    cos_val;
  logic signed [SAMPLE_W-1:0] scaled;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_inc_q   <= BASE_INC_RST;
      step_inc_q   <= STEP_INC_RST;
      active_cnt_q <= ACTIVE_CNT_RST;
      out_gain_q   <= OUT_GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BASE_INC:   base_inc_q   <= cfg_data_i;
        CFG_STEP_INC:   step_inc_q   <= cfg_data_i;
        CFG_ACTIVE_CNT: active_cnt_q <= cfg_data_i[COUNT_W-1:0];
        CFG_OUT_GAIN:   out_gain_q   <= cfg_data_i[GAIN_W-1:0];
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign issue      = (state_q == ST_RUN) && (rd_cnt_q < count_q);
  assign cnt_cmp    = CMP_W'(active_cnt_q);
  assign ld_idx     = LDC_W'(osc_index_i);
  assign new_phase  = ram_rdata + s1_inc_q;

  // phase RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_cnt_q[IDX_W-1:0];
    ram_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_we    = in_xfer && req_type_i && (ld_idx < LDC_W'(MAX_OSCILLATORS));
        ram_waddr = ld_idx[IDX_W-1:0];
        ram_wdata = phase_value_i;
      end
      default: begin
        ram_we    = s1_vld_q;
        ram_waddr = s1_addr_q;
        ram_wdata = new_phase;
      end
    endcase
  end
  assign ram_re = issue;

  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    count_d     = count_q;
    inc_d       = inc_q;
    acc_d       = acc_q;
    scale_start = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    if (s2_vld_q) begin
      acc_d = acc_q + ACC_W'(cos_val);
    end
    unique case (state_q)
      ST_CLEAR: begin
        rd_cnt_d = rd_cnt_q + CNT_W'(1);
        if (rd_cnt_q[IDX_W-1:0] == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer && !req_type_i) begin
          rd_cnt_d = '0;
          inc_d    = base_inc_q;
          acc_d    = '0;
          count_d  = (cnt_cmp > CMP_W'(MAX_OSCILLATORS)) ?
                     CNT_W'(MAX_OSCILLATORS) : CNT_W'(cnt_cmp);
          state_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue) begin
          rd_cnt_d = rd_cnt_q + CNT_W'(1);
          inc_d    = inc_q + step_inc_q;
        end else if (!s1_vld_q && !s2_vld_q) begin
          scale_start = 1'b1;
          state_d     = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (scale_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rd_cnt_q    <= '0;
      count_q     <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      count_q     <= count_d;
      s1_vld_q    <= issue;
      s2_vld_q    <= s1_vld_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inc_q <= inc_d;
    acc_q <= acc_d;
    if (issue) begin
      s1_inc_q  <= inc_q;
      s1_addr_q <= rd_cnt_q[IDX_W-1:0];
    end
    if (out_load) begin
      sample_q <= scaled;
    end
  end

  osb_phase_ram #(
    .DEPTH  (MAX_OSCILLATORS),
    .ADDR_W (IDX_W),
    .DATA_W (PHASE_W)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  osb_cos_rom #(
    .TABLE_BITS (COS_TABLE_BITS)
  ) u_cos_rom (
    .clk_i  (clk_i),
    .addr_i (new_phase[PHASE_W-1 -: COS_TABLE_BITS]),
    .data_o (cos_val)
  );

  osb_scaler #(
    .ACC_W (ACC_W)
  ) u_scaler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scale_start),
    .acc_i    (acc_q),
    .gain_i   (out_gain_q),
    .done_o   (scale_done),
    .sample_o (scaled)
  );

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for oscillator_bank_noise_source. A scoreboard keeps
// its own phase store, cosine table and registers, and computes the expected
// sample for each accepted tick. Short directed items cover the extremes:
// saturation both ways, zero and single oscillator counts, masked register
// data and zero gain. Random phases follow with mostly small banks and one
// full bank. Both handshakes idle at random, except for one long quiet phase.
// ----------------------------------------------------------------------------
import osb_pkg::*;

localparam logic REQ_TICK = 1'b0;
localparam logic REQ_LOAD = 1'b1;

class noise_sample_board;
  localparam int unsigned BANK_SIZE = 256;
  localparam int unsigned TABLE_BITS = 10;
  localparam int unsigned QUARTER_BITS = TABLE_BITS - 2;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint SAMPLE_MAX = 64'sd8388607;
  localparam longint SAMPLE_MIN = -64'sd8388608;

  logic [PHASE_W-1:0] phase_mem [BANK_SIZE];
  int cos_q15 [1 << TABLE_BITS];
  logic [PHASE_W-1:0] base_inc;
  logic [PHASE_W-1:0] step_inc;
  logic [COUNT_W-1:0] active_cnt;
  logic [GAIN_W-1:0] gain;
  logic signed [SAMPLE_W-1:0] pending_samples [$];
  int errors;

  // round(32767 * cos(pi/2 * m / 2^QUARTER_BITS)) by a Q30 Horner series
  function int quarter_cosine(int unsigned m);
    longint unsigned t, x, x2, h, d, v;
    longint unsigned divs [5];
    int i;
    divs = '{64'd90, 64'd56, 64'd30, 64'd12, 64'd2};
    t = 64'(m) << (30 - QUARTER_BITS);
    x = (t * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    h = Q30_ONE;
    for (i = 0; i < 5; i++) begin
      d = (x2 * h) / divs[i];
      h = (d > Q30_ONE) ? 64'd0 : Q30_ONE - d;
    end
    v = (h * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return int'(v);
  endfunction

  function new();
    int unsigned k, r, qsize;
    qsize = 1 << QUARTER_BITS;
    for (k = 0; k < (1 << TABLE_BITS); k++) begin
      r = k & (qsize - 1);
      case ((k >> QUARTER_BITS) & 3)
        0: cos_q15[k] = quarter_cosine(r);
        1: cos_q15[k] = -quarter_cosine(qsize - r);
        2: cos_q15[k] = -quarter_cosine(r);
        default: cos_q15[k] = quarter_cosine(qsize - r);
      endcase
    end
    foreach (phase_mem[i]) phase_mem[i] = '0;
    base_inc = BASE_INC_RST;
    step_inc = STEP_INC_RST;
    active_cnt = ACTIVE_CNT_RST;
    gain = OUT_GAIN_RST;
    errors = 0;
  endfunction

  function void set_register(cfg_idx_e idx, logic [31:0] data);
    case (idx)
      CFG_BASE_INC: base_inc = data;
      CFG_STEP_INC: step_inc = data;
      CFG_ACTIVE_CNT: active_cnt = data[COUNT_W-1:0];
      CFG_OUT_GAIN: gain = data[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  function void take_request(logic kind, logic [INDEX_W-1:0] idx, logic [PHASE_W-1:0] ph);
    int unsigned n, j;
    longint total, s;
    logic [PHASE_W-1:0] inc, np;
    if (kind == REQ_LOAD) begin
      phase_mem[idx] = ph;
      return;
    end
    n = (active_cnt > BANK_SIZE) ? BANK_SIZE : active_cnt;
    total = 0;
    for (j = 0; j < n; j++) begin
      inc = base_inc + j * step_inc;
      np = phase_mem[j] + inc;
      phase_mem[j] = np;
      total += cos_q15[np[PHASE_W-1 -: TABLE_BITS]];
    end
    // Q31 product, half rounds up, down to Q3.20
    s = (total * longint'({48'd0, gain}) + 64'sd1024) >>> ROUND_SHIFT;
    if (s > SAMPLE_MAX) s = SAMPLE_MAX;
    if (s < SAMPLE_MIN) s = SAMPLE_MIN;
    pending_samples.push_back(s[SAMPLE_W-1:0]);
  endfunction

  function void flag(string what, logic signed [SAMPLE_W-1:0] want,
                     logic signed [SAMPLE_W-1:0] got);
    errors++;
    if (errors <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  function void check_sample(logic signed [SAMPLE_W-1:0] got);
    logic signed [SAMPLE_W-1:0] want;
    if (pending_samples.size() == 0) begin
      flag("sample with none pending", 'x, got);
      return;
    end
    want = pending_samples.pop_front();
    if (got !== want) flag("sample mismatch", want, got);
  endfunction
endclass

module tb;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS = 225;
  localparam int RANDOM_PHASES = 8;
  localparam longint RUN_LIMIT_NS = 64'd40_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_e cfg_index = CFG_BASE_INC;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = REQ_TICK;
  logic [INDEX_W-1:0] osc_index = '0;
  logic [PHASE_W-1:0] phase_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  bit gaps_on = 1'b1;

  noise_sample_board board;

  oscillator_bank_noise_source uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .req_type_i(req_type),
    .osc_index_i(osc_index),
    .phase_value_i(phase_value),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .sample_o(sample)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= gaps_on ? ($urandom_range(99) >= 14) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_sample(sample);
  end

  task automatic send_item(input logic kind, input logic [INDEX_W-1:0] idx,
                           input logic [PHASE_W-1:0] ph);
    if (gaps_on)
      while ($urandom_range(99) < 14) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    req_type <= kind;
    osc_index <= idx;
    phase_value <= ph;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_request(kind, idx, ph);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // loads return nothing, so give the bank a full tick's worth of cycles
  task automatic drain_bank();
    in_valid <= 1'b0;
    while (board.pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [31:0] base, input logic [31:0] step,
                             input logic [31:0] cnt, input logic [31:0] gain_val);
    drain_bank();
    write_reg(CFG_BASE_INC, base);
    write_reg(CFG_STEP_INC, step);
    write_reg(CFG_ACTIVE_CNT, cnt);
    write_reg(CFG_OUT_GAIN, gain_val);
  endtask

  task automatic run_random_phase(input int ph);
    int cnt, eff, n;
    logic [31:0] gain_val, step;
    logic kind;
    logic [INDEX_W-1:0] idx;
    gaps_on = (ph != 3);
    // one full bank, the rest small to keep ticks short
    cnt = (ph == 5) ? $urandom_range(256, 511) : $urandom_range(0, 24);
    eff = (cnt > 256) ? 256 : cnt;
    case ($urandom_range(3))
      0: gain_val = 32'h0000_FFFF;
      3: gain_val = $urandom_range(32'h0000_FFFF);
      default: gain_val = (eff == 0) ? 32'd512 :
                          ((131072 / eff > 65535) ? 32'd65535 : 131072 / eff);
    endcase
    step = $urandom_range(1) ? $urandom : $urandom_range(32'h0010_0000);
    reconfigure($urandom, step, {23'($urandom), 9'(cnt)},
                {16'($urandom), 16'(gain_val)});
    for (n = 0; n < PHASE_ITEMS; n++) begin
      kind = ($urandom_range(99) < 35) ? REQ_LOAD : REQ_TICK;
      idx = (eff != 0 && $urandom_range(99) < 70) ? 8'($urandom_range(eff - 1))
                                                   : 8'($urandom_range(255));
      send_item(kind, idx, $urandom);
    end
  endtask

  initial begin
    int ph;
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, all phases zero: every cosine at full scale
    send_item(REQ_TICK, 8'hFF, 32'hFFFF_FFFF);
    // half-turn steps, count data all ones, full gain: saturate low then high
    reconfigure(32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0000_FFFF);
    send_item(REQ_TICK, 8'h00, 32'h0);
    send_item(REQ_TICK, 8'h55, 32'h5555_5555);
    send_item(REQ_LOAD, 8'h00, 32'h0000_0000);
    send_item(REQ_LOAD, 8'hFF, 32'hFFFF_FFFF);
    send_item(REQ_LOAD, 8'h80, 32'h4000_0000);
    send_item(REQ_LOAD, 8'h55, 32'h5555_5555);
    send_item(REQ_LOAD, 8'hAA, 32'hAAAA_AAAA);
    send_item(REQ_TICK, 8'h00, 32'h0);
    // single oscillator, zero gain
    reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'h0);
    send_item(REQ_TICK, 8'h00, 32'h0);
    // count 0x200 masks to zero: no oscillator moves
    reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0200, 32'hFFFF_0200);
    send_item(REQ_TICK, 8'h00, 32'h0);
    send_item(REQ_LOAD, 8'h07, 32'h1234_5678);
    send_item(REQ_TICK, 8'h07, 32'h0);
    // full bank at the nominal 2/N gain
    reconfigure(32'h0, 32'h0100_0000, 32'd256, 32'd512);
    send_item(REQ_TICK, 8'h00, 32'h0);
    send_item(REQ_LOAD, 8'h03, 32'hC000_0000);
    send_item(REQ_TICK, 8'h00, 32'h0);
    send_item(REQ_TICK, 8'h00, 32'h0);

    for (ph = 0; ph < RANDOM_PHASES; ph++) run_random_phase(ph);

    drain_bank();
    if (board.errors == 0 && board.pending_samples.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end
endmodule
